@@ rtl/wosp_pkg.sv @@
// Package for the stereo wavetable oscillator: register indexes, reset values,
// sequencer states and the control bundle of the shared multiply unit.
// No dependencies.
`default_nettype none
package wosp_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_PHASE_INC = 2'd0;
	localparam logic [1:0] CFG_PAN_POS   = 2'd1;
	localparam logic [1:0] CFG_POST_GAIN = 2'd2;

	localparam int CFG_DATA_W   = 24;
	localparam int INC_W        = 24;
	localparam int PAN_W        = 7;
	localparam int GAIN_W       = 16;
	localparam int FRAC_BITS    = 16;
	localparam int POST_SHIFT   = 12;

	localparam logic [INC_W-1:0]  INC_RESET  = 24'd0;
	localparam logic [PAN_W-1:0]  PAN_RESET  = 7'd32;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

	// pi/2 in Q30, used to build the sine table
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RDY  = 8'b0000_0010,
		S_RGR  = 8'b0000_0100,
		S_RGL  = 8'b0000_1000,
		S_ML   = 8'b0001_0000,
		S_MRP  = 8'b0010_0000,
		S_MLP  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	typedef enum logic {
		SH_PAN  = 1'b0,
		SH_POST = 1'b1
	} shift_t;

	typedef struct packed {
		logic   en;
		shift_t shift;
	} mac_ctl_t;

endpackage
`default_nettype wire

@@ rtl/wavetable_oscillator_stereo_pan.sv @@
// Stereo wavetable sine oscillator with constant-power pan and post gain.
// A tick runs through S_RDY, S_RGR, S_RGL, S_ML, S_MRP, S_MLP and S_DONE; the result
// is shown when the output is free. Ticks do not overlap, due to the single table
// read port (sample, right gain, left gain) and one shared multiplier (four products).
// A request with sample_tick low is accepted while idle and gives no result.
// Reset (arst_n low, asynchronous) clears phase and restores register defaults.
`default_nettype none
module wavetable_oscillator_stereo_pan #(
	parameter int TABLE_SIZE   = 256, // power of two, 16 to 4096
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              cfg_we,
	input  wire logic [1:0]                        cfg_addr,
	input  wire logic [wosp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	// tick requests
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [7:0]                        s_tdata, // [0] sample_tick
	// stereo samples
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// left_sample, right_sample from bit 0 up, zero-filled to whole bytes
	output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    m_tdata
);

	localparam int AW      = $clog2(TABLE_SIZE);
	localparam int PHW     = AW + wosp_pkg::FRAC_BITS;
	localparam int QUARTER = TABLE_SIZE / 4;
	localparam int MW      = (SAMPLE_WIDTH > 16 ? SAMPLE_WIDTH : 16) + 1;
	localparam int OTW     = ((2*SAMPLE_WIDTH+7)/8)*8;
	localparam int CW      = AW + wosp_pkg::PAN_W;

	wosp_pkg::state_t state_q;
	wosp_pkg::state_t state_d;

	logic [wosp_pkg::INC_W-1:0]  inc_q;
	logic [wosp_pkg::PAN_W-1:0]  pan_q;
	logic [wosp_pkg::GAIN_W-1:0] post_q;
	logic [PHW-1:0]              phase_q;
	logic [PHW+wosp_pkg::INC_W-1:0] phase_sum;

	logic [AW-1:0] pan_idx;
	logic [AW-1:0] rom_addr;
	logic signed [SAMPLE_WIDTH-1:0] rom_q;

	logic signed [SAMPLE_WIDTH-1:0] y_q;
	logic signed [SAMPLE_WIDTH-1:0] ar_q;
	logic signed [SAMPLE_WIDTH-1:0] al_q;
	logic signed [SAMPLE_WIDTH-1:0] right_q;

	wosp_pkg::mac_ctl_t         mac_ctl;
	logic signed [MW-1:0]       mac_a;
	logic signed [MW-1:0]       mac_b;
	logic signed [SAMPLE_WIDTH-1:0] mac_res;

	logic in_acc;
	logic out_free;

	assign s_tready = (state_q == wosp_pkg::S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	assign phase_sum = (PHW+wosp_pkg::INC_W)'(phase_q) + (PHW+wosp_pkg::INC_W)'(inc_q);

	// clamp pan beyond full right
	always_comb begin
		if (CW'(pan_q) > CW'(QUARTER)) begin
			pan_idx = AW'(QUARTER);
		end else begin
			pan_idx = AW'(pan_q);
		end
	end

	always_comb begin
		case (state_q)
			wosp_pkg::S_RDY: rom_addr = phase_q[PHW-1 -: AW];
			wosp_pkg::S_RGR: rom_addr = pan_idx;
			default:         rom_addr = pan_idx + AW'(QUARTER);
		endcase
	end

	wosp_sine_rom #(
		.TABLE_SIZE  (TABLE_SIZE),
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_rom (
		.clk      (clk),
		.addr     (rom_addr),
		.rd_data_q(rom_q)
	);

	// pan products first, then the post-gain products on their results
	always_comb begin
		mac_ctl.en    = 1'b0;
		mac_ctl.shift = wosp_pkg::SH_PAN;
		mac_a         = MW'(y_q);
		mac_b         = MW'(rom_q);
		case (state_q)
			wosp_pkg::S_RGL, wosp_pkg::S_ML: begin
				mac_ctl.en = 1'b1;
			end
			wosp_pkg::S_MRP: begin
				mac_ctl.en    = 1'b1;
				mac_ctl.shift = wosp_pkg::SH_POST;
				mac_a         = MW'(ar_q);
				mac_b         = $signed(MW'(post_q));
			end
			wosp_pkg::S_MLP: begin
				mac_ctl.en    = 1'b1;
				mac_ctl.shift = wosp_pkg::SH_POST;
				mac_a         = MW'(al_q);
				mac_b         = $signed(MW'(post_q));
			end
			default: begin
				mac_ctl.en = 1'b0;
			end
		endcase
	end

	wosp_mac #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_mac (
		.clk (clk),
		.ctl (mac_ctl),
		.op_a(mac_a),
		.op_b(mac_b),
		.res (mac_res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			wosp_pkg::S_IDLE: begin
				if (in_acc && s_tdata[0]) begin
					state_d = wosp_pkg::S_RDY;
				end
			end
			wosp_pkg::S_RDY:  state_d = wosp_pkg::S_RGR;
			wosp_pkg::S_RGR:  state_d = wosp_pkg::S_RGL;
			wosp_pkg::S_RGL:  state_d = wosp_pkg::S_ML;
			wosp_pkg::S_ML:   state_d = wosp_pkg::S_MRP;
			wosp_pkg::S_MRP:  state_d = wosp_pkg::S_MLP;
			wosp_pkg::S_MLP:  state_d = wosp_pkg::S_DONE;
			wosp_pkg::S_DONE: begin
				if (out_free) begin
					state_d = wosp_pkg::S_IDLE;
				end
			end
			default:          state_d = wosp_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= wosp_pkg::S_IDLE;
			inc_q    <= wosp_pkg::INC_RESET;
			pan_q    <= wosp_pkg::PAN_RESET;
			post_q   <= wosp_pkg::GAIN_RESET;
			phase_q  <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_addr)
					wosp_pkg::CFG_PHASE_INC: inc_q  <= cfg_wdata[wosp_pkg::INC_W-1:0];
					wosp_pkg::CFG_PAN_POS:   pan_q  <= cfg_wdata[wosp_pkg::PAN_W-1:0];
					wosp_pkg::CFG_POST_GAIN: post_q <= cfg_wdata[wosp_pkg::GAIN_W-1:0];
					default: ;
				endcase
			end
			if (in_acc && s_tdata[0]) begin
				phase_q <= phase_sum[PHW-1:0];
			end
			if (state_q == wosp_pkg::S_DONE && out_free) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wosp_pkg::S_RGR) begin
			y_q <= rom_q;
		end
		if (state_q == wosp_pkg::S_ML) begin
			ar_q <= mac_res;
		end
		if (state_q == wosp_pkg::S_MRP) begin
			al_q <= mac_res;
		end
		if (state_q == wosp_pkg::S_MLP) begin
			right_q <= mac_res;
		end
		if (state_q == wosp_pkg::S_DONE && out_free) begin
			m_tdata <= OTW'({right_q, mac_res});
		end
	end

endmodule
`default_nettype wire

@@ rtl/wosp_sine_rom.sv @@
// One-period sine table with a registered read port.
// Contents are built at elaboration from a fixed-point odd Taylor series; uses wosp_pkg.
`default_nettype none
module wosp_sine_rom #(
	parameter int TABLE_SIZE   = 256,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic [$clog2(TABLE_SIZE)-1:0]   addr,
	output logic signed [SAMPLE_WIDTH-1:0]       rd_data_q
);

	localparam int SH = 31 - SAMPLE_WIDTH;
	localparam longint SMAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;

	function automatic logic signed [SAMPLE_WIDTH-1:0] table_entry(input longint idx);
		logic [63:0] p;
		logic [63:0] q;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		longint      mag;
		logic        neg;
		longint      res;
		p   = 64'(idx) << 2;
		neg = 1'b0;
		if (p <= 64'(TABLE_SIZE)) begin
			q = p;
		end else if (p <= 64'(2 * TABLE_SIZE)) begin
			q = 64'(2 * TABLE_SIZE) - p;
		end else if (p <= 64'(3 * TABLE_SIZE)) begin
			q   = p - 64'(2 * TABLE_SIZE);
			neg = 1'b1;
		end else begin
			q   = 64'(4 * TABLE_SIZE) - p;
			neg = 1'b1;
		end
		x    = (wosp_pkg::PI_HALF_Q30 * q + 64'(TABLE_SIZE / 2)) / TABLE_SIZE;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		term = ((term * x2) >> 30) / 6;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 20;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 42;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 72;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 110;
		sum  = sum - longint'(term);
		term = ((term * x2) >> 30) / 156;
		sum  = sum + longint'(term);
		term = ((term * x2) >> 30) / 210;
		sum  = sum - longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > (64'sd1 <<< 30)) begin
			sum = 64'sd1 <<< 30;
		end
		mag = (sum + (64'sd1 <<< (SH - 1))) >>> SH;
		if (mag > SMAX) begin
			mag = SMAX;
		end
		res = neg ? -mag : mag;
		return res[SAMPLE_WIDTH-1:0];
	endfunction

	logic signed [SAMPLE_WIDTH-1:0] tab_w [TABLE_SIZE];

	for (genvar i = 0; i < TABLE_SIZE; i++) begin : g_tab
		localparam logic signed [SAMPLE_WIDTH-1:0] VAL = table_entry(longint'(i));
		assign tab_w[i] = VAL;
	end

	always_ff @(posedge clk) begin
		rd_data_q <= tab_w[addr];
	end

endmodule
`default_nettype wire

@@ rtl/wosp_mac.sv @@
// Shared signed multiplier with round-half-up, right shift and saturation.
// The product is registered; the scaled result follows combinationally. Uses wosp_pkg.
`default_nettype none
module wosp_mac #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                                                  clk,
	input  wire wosp_pkg::mac_ctl_t                                    ctl,
	input  wire logic signed [(SAMPLE_WIDTH > 16 ? SAMPLE_WIDTH : 16):0] op_a,
	input  wire logic signed [(SAMPLE_WIDTH > 16 ? SAMPLE_WIDTH : 16):0] op_b,
	output logic signed [SAMPLE_WIDTH-1:0]                             res
);

	localparam int MW = (SAMPLE_WIDTH > 16 ? SAMPLE_WIDTH : 16) + 1;
	localparam int PW = 2 * MW;
	localparam logic signed [PW:0] RND_PAN  = (PW+1)'(64'sd1 <<< (SAMPLE_WIDTH - 2));
	localparam logic signed [PW:0] RND_POST = (PW+1)'(64'sd1 <<< (wosp_pkg::POST_SHIFT - 1));
	localparam logic signed [PW:0] SMAX_X   =
		(PW+1)'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [PW:0] SMIN_X   = -SMAX_X - (PW+1)'(1);

	logic signed [PW-1:0] prod_s1;
	wosp_pkg::shift_t     shift_s1;
	logic signed [PW:0]   ext;
	logic signed [PW:0]   scaled;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			prod_s1  <= op_a * op_b;
			shift_s1 <= ctl.shift;
		end
	end

	always_comb begin
		ext = {prod_s1[PW-1], prod_s1};
		if (shift_s1 == wosp_pkg::SH_POST) begin
			scaled = (ext + RND_POST) >>> wosp_pkg::POST_SHIFT;
		end else begin
			scaled = (ext + RND_PAN) >>> (SAMPLE_WIDTH - 1);
		end
		if (scaled > SMAX_X) begin
			res = SMAX_X[SAMPLE_WIDTH-1:0];
		end else if (scaled < SMIN_X) begin
			res = SMIN_X[SAMPLE_WIDTH-1:0];
		end else begin
			res = scaled[SAMPLE_WIDTH-1:0];
		end
	end

endmodule
`default_nettype wire

@@ rtl/wosp_checker.sv @@
// Port-level checks for the stereo wavetable oscillator, bound to its top level.
// Depends only on the top-level ports.
`default_nettype none
module wosp_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 s_tvalid,
	input wire logic                                 s_tready,
	input wire logic [7:0]                           s_tdata,
	input wire logic                                 m_tvalid,
	input wire logic                                 m_tready,
	input wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  m_tdata
);

	// a tick request keeps the block busy
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tdata[0]) |=> !s_tready)
		else $error("ready high right after a tick request");

	// an idle request gives nothing and the block stays ready
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tdata[0]) |=> (s_tready && !$rose(m_tvalid)))
		else $error("idle request changed the block");

	// a new result appears only at the end of a computation
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a computation");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

endmodule

bind wavetable_oscillator_stereo_pan wosp_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_wosp_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
`default_nettype wire
